// File: rtl/fcsv_pkg.sv
package fcsv_pkg;

    // Content bytes kept per frame; later bytes are dropped until the end marker.
    localparam int MAX_CHARS = 23;
    localparam int KEPT_W    = $clog2(MAX_CHARS + 1);

    // Configuration register indexes
    localparam logic [1:0] CFG_START_MARKER = 2'd0;
    localparam logic [1:0] CFG_END_MARKER   = 2'd1;
    localparam logic [1:0] CFG_SEPARATOR    = 2'd2;

    localparam logic [7:0] START_MARKER_RST = 8'h3C;  // '<'
    localparam logic [7:0] END_MARKER_RST   = 8'h3E;  // '>'
    localparam logic [7:0] SEPARATOR_RST    = 8'h2C;  // ','

    localparam logic [7:0] CH_DIGIT_0 = 8'h30;
    localparam logic [7:0] CH_DIGIT_1 = 8'h31;
    localparam logic [7:0] CH_DIGIT_9 = 8'h39;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_MINUS   = 8'h2D;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_CR      = 8'h0D;
    localparam logic [7:0] CH_NUL     = 8'h00;

    // LED action codes
    localparam logic [1:0] LED_KEEP = 2'd0;
    localparam logic [1:0] LED_ON   = 2'd1;
    localparam logic [1:0] LED_OFF  = 2'd2;

    typedef struct packed {
        logic [7:0] start_marker;
        logic [7:0] end_marker;
        logic [7:0] separator;
    } t_cfg;

    typedef struct packed {
        logic [7:0]        cmd_first;
        logic [7:0]        cmd_second;
        logic [7:0]        cmd_third;
        logic signed [15:0] left_speed;
        logic signed [15:0] right_speed;
        logic [1:0]        led_action;
    } t_result;

endpackage

// File: rtl/framed_csv_command_parser.sv
// An accepted byte is held in the input register; an end marker's result then
// goes into the output buffer's registers and is shown on the output from there.
// Throughput: one byte per cycle, except that an end marker waits while the output buffer is full;
// a two-entry output buffer keeps input flowing while a result waits on a stalled output.
// Reset (synchronous, active low) closes any open frame, clears the parse state,
// empties both stages and restores the markers to '<', '>' and ','.
module framed_csv_command_parser
    import fcsv_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    // configuration write port
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_index,
    input  logic [7:0]         i_cfg_data,
    // byte input channel
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [7:0]         i_rx_byte,
    // result channel
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [7:0]         o_cmd_first,
    output logic [7:0]         o_cmd_second,
    output logic [7:0]         o_cmd_third,
    output logic signed [15:0] o_left_speed,
    output logic signed [15:0] o_right_speed,
    output logic [1:0]         o_led_action
);

    t_cfg       r_cfg;
    logic       r_in_valid;
    logic [7:0] r_in_byte;

    logic       emit;
    logic       fire;
    logic       push;
    logic       buf_full;
    t_result    core_result;
    t_result    out_result;

    // Configuration registers; index beyond the list is dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.start_marker <= START_MARKER_RST;
            r_cfg.end_marker   <= END_MARKER_RST;
            r_cfg.separator    <= SEPARATOR_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_START_MARKER: r_cfg.start_marker <= i_cfg_data;
                CFG_END_MARKER:   r_cfg.end_marker   <= i_cfg_data;
                CFG_SEPARATOR:    r_cfg.separator    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // The held byte advances unless it makes a result and the output buffer
    // has no free entry. Stall the input only while the held item cannot move.
    assign fire       = r_in_valid && (!emit || !buf_full);
    assign push       = fire && emit;
    assign o_in_stall = r_in_valid && !fire;

    // Input register: load on accept, drop the valid once the byte is consumed.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in_valid && !o_in_stall) begin
            r_in_valid <= 1'b1;
        end else if (fire) begin
            r_in_valid <= 1'b0;
        end
        if (i_in_valid && !o_in_stall) begin
            r_in_byte <= i_rx_byte;
        end
    end

    fcsv_parse_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_byte   (r_in_byte),
        .i_fire   (fire),
        .o_emit   (emit),
        .o_result (core_result)
    );

    fcsv_out_buf u_out_buf (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_result (core_result),
        .i_stall  (i_out_stall),
        .o_valid  (o_out_valid),
        .o_result (out_result),
        .o_full   (buf_full)
    );

    assign o_cmd_first   = out_result.cmd_first;
    assign o_cmd_second  = out_result.cmd_second;
    assign o_cmd_third   = out_result.cmd_third;
    assign o_left_speed  = out_result.left_speed;
    assign o_right_speed = out_result.right_speed;
    assign o_led_action  = out_result.led_action;

    // A result is never pushed into a full buffer.
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> !buf_full)
        else $error("result pushed into full output buffer");

    // A stalled input always has a held item behind it.
    a_stall_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> r_in_valid)
        else $error("input stalled with empty input register");

    // After a push, the output holds a valid result in the next cycle.
    a_push_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |=> o_out_valid)
        else $error("pushed result not presented");

    // The skid entry fills only while the output was stalled.
    a_full_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(buf_full) |-> $past(o_out_valid && i_out_stall))
        else $error("output buffer filled without a stalled result");

endmodule

// File: rtl/fcsv_parse_core.sv
module fcsv_parse_core
    import fcsv_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cfg       i_cfg,
    input  logic [7:0] i_byte,
    input  logic       i_fire,
    output logic       o_emit,
    output t_result    o_result
);

    typedef enum logic [1:0] {
        PH_SKIP   = 2'd0,
        PH_DIGITS = 2'd1,
        PH_DONE   = 2'd2
    } t_phase;

    typedef struct packed {
        logic [15:0] mag;
        logic        neg;
        t_phase      phase;
    } t_num;

    logic              r_in_frame,  n_in_frame;
    logic [KEPT_W-1:0] r_kept,      n_kept;
    logic              r_closed,    n_closed;
    logic [1:0]        r_field,     n_field;
    logic              r_in_field,  n_in_field;
    logic [7:0]        r_chars [3];
    logic [7:0]        n_chars [3];
    logic [1:0]        r_cmd_cnt,   n_cmd_cnt;
    t_phase            r_phase,     n_phase;
    logic              r_neg_l,     n_neg_l;
    logic              r_neg_r,     n_neg_r;
    logic [15:0]       r_mag_l,     n_mag_l;
    logic [15:0]       r_mag_r,     n_mag_r;

    function automatic logic is_space(input logic [7:0] c);
        return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
    endfunction

    // One atoi step: digits accumulate with saturation at 32768.
    function automatic t_num number_step(input logic [7:0] c, input t_num cur);
        t_num        res;
        logic [19:0] v;
        logic [7:0]  d;
        res = cur;
        d   = c - CH_DIGIT_0;
        v   = ({4'b0, cur.mag} << 3) + ({4'b0, cur.mag} << 1) + {16'b0, d[3:0]};
        if (cur.phase == PH_DONE) begin
            res = cur;
        end else if (c >= CH_DIGIT_0 && c <= CH_DIGIT_9) begin
            res.mag   = (v > 20'd32768) ? 16'h8000 : v[15:0];
            res.phase = PH_DIGITS;
        end else if (cur.phase == PH_SKIP && is_space(c)) begin
            res = cur;
        end else if (cur.phase == PH_SKIP && (c == CH_PLUS || c == CH_MINUS)) begin
            res.neg   = (c == CH_MINUS);
            res.phase = PH_DIGITS;
        end else begin
            res.phase = PH_DONE;
        end
        return res;
    endfunction

    function automatic logic signed [15:0] signed_out(input logic [15:0] mag,
                                                      input logic neg);
        if (neg) begin
            return 16'd0 - mag;
        end
        return (mag > 16'd32767) ? 16'sd32767 : mag;
    endfunction

    assign o_emit = r_in_frame && (i_byte == i_cfg.end_marker);

    always_comb begin
        o_result.cmd_first   = r_chars[0];
        o_result.cmd_second  = r_chars[1];
        o_result.cmd_third   = r_chars[2];
        o_result.left_speed  = signed_out(r_mag_l, r_neg_l);
        o_result.right_speed = signed_out(r_mag_r, r_neg_r);
        if (r_chars[2] == CH_DIGIT_1) begin
            o_result.led_action = LED_ON;
        end else if (r_chars[2] == CH_DIGIT_0) begin
            o_result.led_action = LED_OFF;
        end else begin
            o_result.led_action = LED_KEEP;
        end
    end

    always_comb begin
        t_num   num;
        t_phase ph;
        n_in_frame = r_in_frame;
        n_kept     = r_kept;
        n_closed   = r_closed;
        n_field    = r_field;
        n_in_field = r_in_field;
        n_chars    = r_chars;
        n_cmd_cnt  = r_cmd_cnt;
        n_phase    = r_phase;
        n_neg_l    = r_neg_l;
        n_neg_r    = r_neg_r;
        n_mag_l    = r_mag_l;
        n_mag_r    = r_mag_r;
        ph         = r_in_field ? r_phase : PH_SKIP;
        num        = '{mag: 16'd0, neg: 1'b0, phase: PH_SKIP};

        if ((!r_in_frame && i_byte == i_cfg.start_marker) || o_emit) begin
            // open or close a frame: clear all parse state
            n_in_frame = !r_in_frame;
            n_kept     = '0;
            n_closed   = 1'b0;
            n_field    = 2'd0;
            n_in_field = 1'b0;
            n_chars    = '{default: 8'd0};
            n_cmd_cnt  = 2'd0;
            n_phase    = PH_SKIP;
            n_neg_l    = 1'b0;
            n_neg_r    = 1'b0;
            n_mag_l    = 16'd0;
            n_mag_r    = 16'd0;
        end else if (r_in_frame && r_kept < KEPT_W'(MAX_CHARS)) begin
            n_kept = r_kept + KEPT_W'(1);
            if (r_closed) begin
                n_closed = 1'b1;
            end else if (i_byte == CH_NUL) begin
                n_closed = 1'b1;
            end else if (i_byte == i_cfg.separator) begin
                if (r_in_field) begin
                    n_in_field = 1'b0;
                    if (r_field != 2'd3) begin
                        n_field = r_field + 2'd1;
                    end
                end
            end else begin
                n_in_field = 1'b1;
                n_phase    = ph;
                unique case (r_field)
                    2'd0: begin
                        unique case (r_cmd_cnt)
                            2'd0: n_chars[0] = i_byte;
                            2'd1: n_chars[1] = i_byte;
                            2'd2: n_chars[2] = i_byte;
                            default: ;
                        endcase
                        if (r_cmd_cnt != 2'd3) begin
                            n_cmd_cnt = r_cmd_cnt + 2'd1;
                        end
                    end
                    2'd1: begin
                        num     = number_step(i_byte, '{mag: r_mag_l, neg: r_neg_l, phase: ph});
                        n_mag_l = num.mag;
                        n_neg_l = num.neg;
                        n_phase = num.phase;
                    end
                    2'd2: begin
                        num     = number_step(i_byte, '{mag: r_mag_r, neg: r_neg_r, phase: ph});
                        n_mag_r = num.mag;
                        n_neg_r = num.neg;
                        n_phase = num.phase;
                    end
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_frame <= 1'b0;
            r_kept     <= '0;
            r_closed   <= 1'b0;
            r_field    <= 2'd0;
            r_in_field <= 1'b0;
            r_chars    <= '{default: 8'd0};
            r_cmd_cnt  <= 2'd0;
            r_phase    <= PH_SKIP;
            r_neg_l    <= 1'b0;
            r_neg_r    <= 1'b0;
            r_mag_l    <= 16'd0;
            r_mag_r    <= 16'd0;
        end else if (i_fire) begin
            r_in_frame <= n_in_frame;
            r_kept     <= n_kept;
            r_closed   <= n_closed;
            r_field    <= n_field;
            r_in_field <= n_in_field;
            r_chars    <= n_chars;
            r_cmd_cnt  <= n_cmd_cnt;
            r_phase    <= n_phase;
            r_neg_l    <= n_neg_l;
            r_neg_r    <= n_neg_r;
            r_mag_l    <= n_mag_l;
            r_mag_r    <= n_mag_r;
        end
    end

endmodule

// File: rtl/fcsv_out_buf.sv
module fcsv_out_buf
    import fcsv_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_result i_result,
    input  logic    i_stall,
    output logic    o_valid,
    output t_result o_result,
    output logic    o_full
);

    logic    r_main_valid, n_main_valid;
    logic    r_skid_valid, n_skid_valid;
    t_result r_main,       n_main;
    t_result r_skid,       n_skid;
    logic    pop;

    assign pop      = r_main_valid && !i_stall;
    assign o_valid  = r_main_valid;
    assign o_result = r_main;
    assign o_full   = r_skid_valid;

    always_comb begin
        n_main_valid = r_main_valid;
        n_skid_valid = r_skid_valid;
        n_main       = r_main;
        n_skid       = r_skid;
        if (pop) begin
            if (r_skid_valid) begin
                n_main       = r_skid;
                n_skid       = i_result;
                n_skid_valid = i_push;
            end else begin
                n_main       = i_result;
                n_main_valid = i_push;
            end
        end else if (i_push) begin
            if (!r_main_valid) begin
                n_main       = i_result;
                n_main_valid = 1'b1;
            end else begin
                n_skid       = i_result;
                n_skid_valid = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_main_valid <= n_main_valid;
            r_skid_valid <= n_skid_valid;
        end
        r_main <= n_main;
        r_skid <= n_skid;
    end

endmodule
